// ===== rtl/mna_pkg.sv =====
// Package for the MNA matrix stamper: status codes, element and store codes.
// No dependencies.
package mna_pkg;

    localparam int ACC_W = 48;
    localparam int MAX_DIM = 64;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [2:0] ET_RES = 3'd0;
    localparam logic [2:0] ET_VSRC = 3'd1;
    localparam logic [2:0] ET_ISRC = 3'd2;
    localparam logic [2:0] ET_CAP = 3'd3;
    localparam logic [2:0] ET_IND = 3'd4;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_C = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;
    localparam logic [1:0] SEL_BAD = 2'd3;

    localparam logic CFG_NODES = 1'b0;
    localparam logic CFG_TRAN  = 1'b1;

    localparam logic [1:0] MEM_A = 2'd0;
    localparam logic [1:0] MEM_C = 2'd1;
    localparam logic [1:0] MEM_B = 2'd2;

    // one queued accumulation
    typedef struct packed {
        logic             en;
        logic [1:0]       mem;
        logic [6:0]       row;
        logic [6:0]       col;
        logic signed [ACC_W-1:0] delta;
    } acc_op_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b,
        output logic                   hit
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        hit = 1'b0;
        if (s[ACC_W] != s[ACC_W-1]) begin
            hit = 1'b1;
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== rtl/mna_matrix_stamper.sv =====
// MNA matrix stamper top level: stores, sequencer, reciprocal divider.
// Depends on mna_pkg.
//
// Each transaction returns one result. A stamp is decoded into up to five
// accumulations, each a read-modify-write of one memory entry (read, then
// saturating add and write back). A resistor first runs a restoring divider
// for 2^32/R, one quotient bit per cycle. After reset a clearing pass over
// all MAX_DIM*MAX_DIM (4096) addresses zeroes the stores; no transaction is
// accepted meanwhile. One item is in flight at a time; the result register
// frees the input as soon as it is loaded.
module mna_matrix_stamper
    import mna_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [2:0]         s_element_type,
    input  logic [6:0]         s_node_pos,
    input  logic [6:0]         s_node_neg,
    input  logic signed [31:0] s_elem_value,
    input  logic [1:0]         s_store_select,
    input  logic [5:0]         s_read_row,
    input  logic [5:0]         s_read_col,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_read_value,
    output logic [6:0]         m_branch_index,
    output logic [1:0]         m_status
);

    localparam int AW = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int DW = 2 * AW;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_RD = 3'd3;
    localparam logic [2:0] S_WR = 3'd4;
    localparam logic [2:0] S_RRD = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic signed [ACC_W-1:0] mem_a [DEPTH];
    logic signed [ACC_W-1:0] mem_c [DEPTH];
    logic signed [ACC_W-1:0] mem_b [MAX_DIM];

    logic [2:0] state_reg;
    logic [DW:0] clr_reg;
    logic [6:0] nodes_reg;
    logic tran_reg;
    logic [6:0] branch_reg;
    acc_op_t ops_reg [5];
    logic [2:0] op_idx_reg;
    logic sat_reg;
    logic [1:0] res_stat_reg;
    logic signed [ACC_W-1:0] res_val_reg;
    logic out_valid_reg;
    logic signed [ACC_W-1:0] out_val_reg;
    logic [6:0] out_br_reg;
    logic [1:0] out_st_reg;

    // divider
    logic [33:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [32:0] quo_reg;
    logic [5:0] div_cnt_reg;
    logic div_neg_reg;
    logic [6:0] dp_reg, dn_reg;

    // memory read port
    logic rd_en;
    logic [1:0] rd_mem;
    logic [DW-1:0] rd_addr;
    logic [AW-1:0] rd_baddr;
    logic signed [ACC_W-1:0] rd_a_reg, rd_c_reg, rd_b_reg;
    logic [1:0] rd_mem_reg;
    logic signed [ACC_W-1:0] rd_data;

    // write port
    logic wr_en;
    logic [1:0] wr_mem;
    logic [DW-1:0] wr_addr;
    logic signed [ACC_W-1:0] wr_data;

    acc_op_t cur_op;
    logic signed [ACC_W-1:0] sum;
    logic sum_hit;

    logic s_fire;
    logic [7:0] br_row;
    logic bad;
    logic signed [ACC_W-1:0] v48, g48;
    acc_op_t ops_new [5];

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_read_value = out_val_reg;
    assign m_branch_index = out_br_reg;
    assign m_status = out_st_reg;

    assign cur_op = ops_reg[op_idx_reg];
    assign rd_data = (rd_mem_reg == MEM_A) ? rd_a_reg :
                     (rd_mem_reg == MEM_C) ? rd_c_reg : rd_b_reg;
    always_comb sum = sat_add(rd_data, cur_op.delta, sum_hit);

    always_comb begin
        rd_en = 1'b0;
        rd_mem = cur_op.mem;
        rd_addr = {cur_op.row[AW-1:0], cur_op.col[AW-1:0]};
        rd_baddr = cur_op.row[AW-1:0];
        if (state_reg == S_RD) begin
            rd_en = cur_op.en;
        end else if (s_fire && s_kind) begin
            rd_en = 1'b1;
            rd_mem = s_store_select;
            rd_addr = {s_read_row[AW-1:0], s_read_col[AW-1:0]};
            rd_baddr = s_read_row[AW-1:0];
        end
    end

    always_comb begin
        wr_en = 1'b0;
        wr_mem = cur_op.mem;
        wr_addr = {cur_op.row[AW-1:0], cur_op.col[AW-1:0]};
        wr_data = sum;
        if (state_reg == S_CLR) begin
            wr_en = 1'b1;
            wr_mem = MEM_A;
            wr_addr = clr_reg[DW-1:0];
            wr_data = '0;
        end else if (state_reg == S_WR) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem_a[rd_addr];
            rd_c_reg <= mem_c[rd_addr];
            rd_b_reg <= mem_b[rd_baddr];
            rd_mem_reg <= rd_mem;
        end
        if (wr_en) begin
            if (state_reg == S_CLR || wr_mem == MEM_A) mem_a[wr_addr] <= wr_data;
            if (state_reg == S_CLR || wr_mem == MEM_C) mem_c[wr_addr] <= wr_data;
            if ((state_reg == S_CLR && wr_addr[DW-1:AW] == '0) || wr_mem == MEM_B) begin
                mem_b[(state_reg == S_CLR) ? wr_addr[AW-1:0] : wr_addr[DW-1:AW]]
                    <= wr_data;
            end
        end
    end

    // stamp decode
    always_comb begin
        logic [7:0] pm, nm;
        logic pz, nz;
        pm = {1'b0, s_node_pos} - 8'd1;
        nm = {1'b0, s_node_neg} - 8'd1;
        pz = (s_node_pos == '0);
        nz = (s_node_neg == '0);
        br_row = {1'b0, nodes_reg} + {1'b0, branch_reg};
        v48 = ACC_W'(s_elem_value);
        bad = (s_element_type > ET_IND) || (s_node_pos > nodes_reg)
            || (s_node_neg > nodes_reg) || (32'(s_node_pos) > 32'(MAX_DIM))
            || (32'(s_node_neg) > 32'(MAX_DIM));
        if ((s_element_type == ET_VSRC || s_element_type == ET_IND)
            && ((32'(br_row) >= 32'(MAX_DIM)) || branch_reg >= 7'd127)) begin
            bad = 1'b1;
        end
        for (int i = 0; i < 5; i++) ops_new[i] = '0;
        unique case (s_element_type)
            ET_ISRC: begin
                ops_new[0] = '{!pz, MEM_B, pm[6:0], 7'd0, -v48};
                ops_new[1] = '{!nz, MEM_B, nm[6:0], 7'd0, v48};
            end
            ET_CAP: begin
                ops_new[0] = '{tran_reg && !pz && !nz, MEM_C, pm[6:0], nm[6:0], -v48};
                ops_new[1] = '{tran_reg && !pz && !nz, MEM_C, nm[6:0], pm[6:0], -v48};
                ops_new[2] = '{tran_reg && !pz, MEM_C, pm[6:0], pm[6:0], v48};
                ops_new[3] = '{tran_reg && !nz, MEM_C, nm[6:0], nm[6:0], v48};
            end
            ET_VSRC, ET_IND: begin
                ops_new[0] = '{!pz, MEM_A, br_row[6:0], pm[6:0], 48'sd65536};
                ops_new[1] = '{!nz, MEM_A, br_row[6:0], nm[6:0], -48'sd65536};
                ops_new[2] = '{!pz, MEM_A, pm[6:0], br_row[6:0], 48'sd65536};
                ops_new[3] = '{!nz, MEM_A, nm[6:0], br_row[6:0], -48'sd65536};
                if (s_element_type == ET_VSRC)
                    ops_new[4] = '{1'b1, MEM_B, br_row[6:0], 7'd0, v48};
                else
                    ops_new[4] = '{tran_reg, MEM_C, br_row[6:0], br_row[6:0], -v48};
            end
            default: ;
        endcase
    end

    // quotient of 2^32 / |R| with sign, as a Q32.16 delta
    always_comb begin
        logic [33:0] q;
        q = div_neg_reg ? (34'd0 - {1'b0, quo_reg}) : {1'b0, quo_reg};
        g48 = ACC_W'($signed(q));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            nodes_reg <= '0;
            tran_reg <= 1'b0;
            branch_reg <= '0;
            out_valid_reg <= 1'b0;
            op_idx_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NODES) nodes_reg <= cfg_wdata;
                else tran_reg <= cfg_wdata[0];
            end
            if (out_valid_reg && m_ready && state_reg != S_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (DW+1)'(DEPTH - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_fire) begin
                        sat_reg <= 1'b0;
                        res_val_reg <= '0;
                        op_idx_reg <= '0;
                        if (s_kind) begin
                            res_stat_reg <= (s_store_select == SEL_BAD) ? ST_IDX : ST_OK;
                            state_reg <= S_RRD;
                        end else begin
                            for (int i = 0; i < 5; i++) ops_reg[i] <= ops_new[i];
                            if (bad) begin
                                res_stat_reg <= ST_IDX;
                                state_reg <= S_OUT;
                            end else if (s_element_type == ET_RES) begin
                                if (s_elem_value == '0) begin
                                    res_stat_reg <= ST_ZERO;
                                    state_reg <= S_OUT;
                                end else begin
                                    res_stat_reg <= ST_OK;
                                    rem_reg <= '0;
                                    dvs_reg <= s_elem_value[31]
                                        ? (33'd0 - {s_elem_value[31], s_elem_value})
                                        : {1'b0, s_elem_value};
                                    div_neg_reg <= s_elem_value[31];
                                    quo_reg <= '0;
                                    div_cnt_reg <= 6'd33;
                                    dp_reg <= s_node_pos;
                                    dn_reg <= s_node_neg;
                                    state_reg <= S_DIV;
                                end
                            end else begin
                                res_stat_reg <= ST_OK;
                                if (s_element_type == ET_VSRC || s_element_type == ET_IND)
                                    branch_reg <= branch_reg + 7'd1;
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_DIV: begin
                    // restoring step on dividend 2^32, one bit per cycle
                    begin
                        logic [33:0] r2;
                        r2 = {rem_reg[32:0], (div_cnt_reg == 6'd33) ? 1'b0 :
                              (div_cnt_reg == 6'd32)};
                        if (r2 >= {1'b0, dvs_reg}) begin
                            rem_reg <= r2 - {1'b0, dvs_reg};
                            quo_reg <= {quo_reg[31:0], 1'b1};
                        end else begin
                            rem_reg <= r2;
                            quo_reg <= {quo_reg[31:0], 1'b0};
                        end
                    end
                    if (div_cnt_reg == '0) begin
                        state_reg <= S_RD;
                    end
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                end
                S_RD: begin
                    if (op_idx_reg == 3'd0 && div_cnt_reg == 6'h3f) begin
                        // resistor ops built once the quotient is ready
                        ops_reg[0] <= '{dp_reg != 0 && dn_reg != 0, MEM_A,
                                        dp_reg - 7'd1, dn_reg - 7'd1, -g48};
                        ops_reg[1] <= '{dp_reg != 0 && dn_reg != 0, MEM_A,
                                        dn_reg - 7'd1, dp_reg - 7'd1, -g48};
                        ops_reg[2] <= '{dp_reg != 0, MEM_A, dp_reg - 7'd1,
                                        dp_reg - 7'd1, g48};
                        ops_reg[3] <= '{dn_reg != 0, MEM_A, dn_reg - 7'd1,
                                        dn_reg - 7'd1, g48};
                        ops_reg[4] <= '0;
                        div_cnt_reg <= '0;
                    end else if (cur_op.en) begin
                        state_reg <= S_WR;
                    end else if (op_idx_reg == 3'd4) begin
                        state_reg <= S_OUT;
                    end else begin
                        op_idx_reg <= op_idx_reg + 3'd1;
                    end
                end
                S_WR: begin
                    if (sum_hit) sat_reg <= 1'b1;
                    if (op_idx_reg == 3'd4) begin
                        state_reg <= S_OUT;
                    end else begin
                        op_idx_reg <= op_idx_reg + 3'd1;
                        state_reg <= S_RD;
                    end
                end
                S_RRD: begin
                    if (res_stat_reg == ST_OK) res_val_reg <= rd_data;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the previous result has been taken
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_val_reg <= res_val_reg;
                        out_br_reg <= branch_reg;
                        out_st_reg <= (res_stat_reg == ST_OK && sat_reg) ? ST_SAT
                                                                         : res_stat_reg;
                        div_cnt_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/sv/mna_matrix_stamper_test.sv =====
// Self-checking testbench for mna_matrix_stamper: stamps and reads driven over
// valid/ready, results checked against an in-bench model of the three stores.
// Depends on mna_pkg and the mna_matrix_stamper RTL.
module mna_matrix_stamper_test;
    import mna_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 64;
    localparam longint Q_MAX = 64'sd140737488355327;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam longint ONE_Q = 64'sd65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ET_UNUSED_LO = 3'd5;
    localparam logic [2:0] ET_UNUSED_HI = 3'd7;

    typedef struct {
        logic        kind;
        logic [2:0]  etype;
        logic [6:0]  npos;
        logic [6:0]  nneg;
        logic [31:0] val;
        logic [1:0]  sel;
        logic [5:0]  row;
        logic [5:0]  col;
    } stamp_req_t;

    typedef struct {
        logic [47:0] value;
        logic [6:0]  branch;
        logic [1:0]  status;
    } entry_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic [2:0] s_element_type = '0;
    logic [6:0] s_node_pos = '0;
    logic [6:0] s_node_neg = '0;
    logic signed [31:0] s_elem_value = '0;
    logic [1:0] s_store_select = '0;
    logic [5:0] s_read_row = '0;
    logic [5:0] s_read_col = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [47:0] m_read_value;
    logic [6:0] m_branch_index;
    logic [1:0] m_status;

    mna_matrix_stamper u_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // model state
    longint mdl_a [DIM*DIM];
    longint mdl_c [DIM*DIM];
    longint mdl_b [DIM];
    int     mdl_branches = 0;
    int     mdl_nodes = 0;
    bit     mdl_tran = 1'b0;
    bit     sat_flag;

    stamp_req_t  pending_q [$];
    entry_resp_t awaited_q [$];
    int  n_pushed = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_sat = 0;
    int  n_idx = 0;
    int  n_zero = 0;
    bit  no_gaps = 1'b0;
    bit  quiet = 1'b0;
    int  cycles = 0;

    function automatic int draw_wait();
        return (no_gaps || quiet) ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic longint sat_sum(longint x, longint d);
        longint s;
        s = x + d;
        if (s > Q_MAX) begin s = Q_MAX; sat_flag = 1'b1; end
        if (s < Q_MIN) begin s = Q_MIN; sat_flag = 1'b1; end
        return s;
    endfunction

    function automatic void pair_into_a(int p, int n, longint d);
        if (p != 0 && n != 0) begin
            mdl_a[(p-1)*DIM + n-1] = sat_sum(mdl_a[(p-1)*DIM + n-1], -d);
            mdl_a[(n-1)*DIM + p-1] = sat_sum(mdl_a[(n-1)*DIM + p-1], -d);
        end
        if (p != 0) mdl_a[(p-1)*DIM + p-1] = sat_sum(mdl_a[(p-1)*DIM + p-1], d);
        if (n != 0) mdl_a[(n-1)*DIM + n-1] = sat_sum(mdl_a[(n-1)*DIM + n-1], d);
    endfunction

    function automatic void pair_into_c(int p, int n, longint d);
        if (p != 0 && n != 0) begin
            mdl_c[(p-1)*DIM + n-1] = sat_sum(mdl_c[(p-1)*DIM + n-1], -d);
            mdl_c[(n-1)*DIM + p-1] = sat_sum(mdl_c[(n-1)*DIM + p-1], -d);
        end
        if (p != 0) mdl_c[(p-1)*DIM + p-1] = sat_sum(mdl_c[(p-1)*DIM + p-1], d);
        if (n != 0) mdl_c[(n-1)*DIM + n-1] = sat_sum(mdl_c[(n-1)*DIM + n-1], d);
    endfunction

    // apply one transaction to the stores, return the entry it produces
    function automatic entry_resp_t stamp_or_read(stamp_req_t t);
        entry_resp_t r;
        longint rv, v;
        int p, n, br;
        bit bad;
        rv = 0;
        r.status = ST_OK;
        if (t.kind) begin
            if (t.sel == SEL_BAD) r.status = ST_IDX;
            else if (t.sel == SEL_A) rv = mdl_a[t.row*DIM + t.col];
            else if (t.sel == SEL_C) rv = mdl_c[t.row*DIM + t.col];
            else rv = mdl_b[t.row];
        end else begin
            p = t.npos;
            n = t.nneg;
            v = longint'(signed'(t.val));
            br = mdl_nodes + mdl_branches;
            bad = t.etype > ET_IND || p > mdl_nodes || n > mdl_nodes || p > DIM || n > DIM;
            if ((t.etype == ET_VSRC || t.etype == ET_IND) && (br >= DIM || mdl_branches >= 127))
                bad = 1'b1;
            sat_flag = 1'b0;
            if (bad) r.status = ST_IDX;
            else if (t.etype == ET_RES && v == 0) r.status = ST_ZERO;
            else if (t.etype == ET_RES) pair_into_a(p, n, 64'sd4294967296 / v);
            else if (t.etype == ET_ISRC) begin
                if (p != 0) mdl_b[p-1] = sat_sum(mdl_b[p-1], -v);
                if (n != 0) mdl_b[n-1] = sat_sum(mdl_b[n-1], v);
            end else if (t.etype == ET_CAP) begin
                if (mdl_tran) pair_into_c(p, n, v);
            end else begin
                mdl_branches++;
                if (t.etype == ET_VSRC) mdl_b[br] = sat_sum(mdl_b[br], v);
                if (p != 0) mdl_a[br*DIM + p-1] = sat_sum(mdl_a[br*DIM + p-1], ONE_Q);
                if (n != 0) mdl_a[br*DIM + n-1] = sat_sum(mdl_a[br*DIM + n-1], -ONE_Q);
                if (p != 0) mdl_a[(p-1)*DIM + br] = sat_sum(mdl_a[(p-1)*DIM + br], ONE_Q);
                if (n != 0) mdl_a[(n-1)*DIM + br] = sat_sum(mdl_a[(n-1)*DIM + br], -ONE_Q);
                if (t.etype == ET_IND && mdl_tran)
                    mdl_c[br*DIM + br] = sat_sum(mdl_c[br*DIM + br], -v);
            end
            if (r.status == ST_OK && sat_flag) r.status = ST_SAT;
        end
        r.value = rv[47:0];
        r.branch = mdl_branches[6:0];
        return r;
    endfunction

    // driver: hold payload until accepted, then wait the drawn gap
    int gap_left = 0;
    always @(posedge aclk) begin : drive_blk
        stamp_req_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_q.push_back(stamp_or_read('{s_kind, s_element_type, s_node_pos,
                    s_node_neg, s_elem_value, s_store_select, s_read_row, s_read_col}));
            end
            if (s_valid && !s_ready) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                t = pending_q.pop_front();
                s_kind <= t.kind;
                s_element_type <= t.etype;
                s_node_pos <= t.npos;
                s_node_neg <= t.nneg;
                s_elem_value <= t.val;
                s_store_select <= t.sel;
                s_read_row <= t.row;
                s_read_col <= t.col;
                s_valid <= 1'b1;
                gap_left <= draw_wait();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    int stall_left = 0;
    always @(posedge aclk) begin : watch_blk
        entry_resp_t e;
        int st;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            st = stall_left;
            if (m_valid && m_ready) begin
                n_checked++;
                if (awaited_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: value %0d branch %0d status %0d",
                                 m_read_value, m_branch_index, m_status);
                end else begin
                    e = awaited_q.pop_front();
                    if (m_status == ST_SAT) n_sat++;
                    if (m_status == ST_IDX) n_idx++;
                    if (m_status == ST_ZERO) n_zero++;
                    if (m_read_value !== e.value || m_branch_index !== e.branch ||
                        m_status !== e.status) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch #%0d: exp value %0d branch %0d status %0d,",
                                      " got %0d %0d %0d"},
                                     n_checked, signed'(e.value), e.branch, e.status,
                                     m_read_value, m_branch_index, m_status);
                    end
                end
                st = draw_wait();
            end
            if (st > 0) begin
                stall_left <= st - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= 0;
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, n_pushed - n_checked);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_item(logic k, logic [2:0] et, logic [6:0] p, logic [6:0] n,
                            logic [31:0] v, logic [1:0] sel, logic [5:0] r, logic [5:0] c);
        pending_q.push_back('{k, et, p, n, v, sel, r, c});
        n_pushed++;
    endtask

    task automatic add_stamp(logic [2:0] et, logic [6:0] p, logic [6:0] n, logic [31:0] v);
        add_item(1'b0, et, p, n, v, 2'($urandom), 6'($urandom), 6'($urandom));
    endtask

    task automatic add_read(logic [1:0] sel, logic [5:0] r, logic [5:0] c);
        add_item(1'b1, 3'($urandom), 7'($urandom), 7'($urandom), $urandom, sel, r, c);
    endtask

    task automatic drain();
        while (n_checked != n_pushed || pending_q.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_NODES) mdl_nodes = d;
        else mdl_tran = d[0];
    endtask

    function automatic logic [6:0] pick_node();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 7'($urandom);
        if (k == 1) return 7'(mdl_nodes + 1);
        return 7'($urandom_range(0, mdl_nodes));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return $urandom_range(0, 2);
            4: return -$urandom_range(1, 70000);
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    // mostly well-formed stamps onto the live nodes, reads biased to used rows
    task automatic add_random();
        int used;
        logic [1:0] sel;
        used = mdl_nodes + mdl_branches;
        if (used > DIM - 1) used = DIM - 1;
        if ($urandom_range(0, 2) == 0) begin
            sel = ($urandom_range(0, 9) == 0) ? SEL_BAD : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 4) == 0) add_read(sel, 6'($urandom), 6'($urandom));
            else add_read(sel, 6'($urandom_range(0, used)), 6'($urandom_range(0, used)));
        end else begin
            add_stamp(($urandom_range(0, 24) == 0)
                          ? 3'($urandom_range(ET_UNUSED_LO, ET_UNUSED_HI))
                          : 3'($urandom_range(0, 4)),
                      pick_node(), pick_node(), pick_value());
        end
    endtask

    int phase_nodes [6] = '{3, 64, 0, 12, 30, 7};

    initial begin
        for (int i = 0; i < DIM*DIM; i++) begin
            mdl_a[i] = 0;
            mdl_c[i] = 0;
        end
        for (int i = 0; i < DIM; i++) mdl_b[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ground-only circuit, then a small one with every element kind
        add_read(SEL_A, 0, 0);
        add_stamp(ET_RES, 0, 0, 32'd5);
        add_stamp(ET_VSRC, 0, 0, 32'd1);
        drain();
        write_reg(CFG_NODES, 7'd4);
        write_reg(CFG_TRAN, 7'd1);
        add_stamp(ET_RES, 1, 2, 32'd1);
        add_stamp(ET_RES, 2, 3, 32'hffff_ffff);
        add_stamp(ET_RES, 3, 0, 32'h8000_0000);
        add_stamp(ET_RES, 4, 4, 32'h7fff_ffff);
        add_stamp(ET_RES, 1, 3, 32'd0);
        add_stamp(ET_RES, 5, 1, 32'd9);
        add_stamp(ET_RES, 1, 127, 32'd9);
        add_stamp(ET_UNUSED_LO, 1, 2, 32'd1);
        add_stamp(ET_UNUSED_HI, 1, 2, 32'd1);
        add_stamp(ET_VSRC, 1, 0, 32'h0001_0000);
        add_stamp(ET_IND, 0, 2, 32'hfffe_0000);
        add_stamp(ET_CAP, 3, 3, 32'h0000_8000);
        add_stamp(ET_CAP, 2, 4, 32'h7fff_ffff);
        add_stamp(ET_ISRC, 2, 4, 32'h8000_0000);
        add_read(SEL_A, 4, 0);
        add_read(SEL_C, 4, 4);
        add_read(SEL_B, 4, 63);
        add_read(SEL_BAD, 1, 1);
        add_read(SEL_A, 63, 63);
        drain();
        write_reg(CFG_TRAN, 7'd0);
        add_stamp(ET_CAP, 1, 2, 32'd77);
        add_stamp(ET_IND, 1, 2, 32'd77);
        add_read(SEL_C, 1, 1);
        drain();

        // back-to-back current sources into B[0] and B[1]
        no_gaps = 1'b1;
        for (int i = 0; i < 200; i++) add_stamp(ET_ISRC, 1, 2, 32'h8000_0000);
        add_read(SEL_B, 0, 0);
        add_read(SEL_B, 1, 0);
        drain();
        no_gaps = 1'b0;

        // random phases over several node counts, transient both ways
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_NODES, 7'(phase_nodes[ph]));
            write_reg(CFG_TRAN, 7'(ph[0]));
            for (int i = 0; i < 260; i++) begin
                if (i % 65 == 0) quiet = ($urandom_range(0, 2) == 0);
                add_random();
            end
            drain();
        end
        quiet = 1'b0;

        $display("checked %0d transactions: %0d index errors, %0d zero resistances, %0d saturated",
                 n_checked, n_idx, n_zero, n_sat);
        $display("final branch rows %0d, mismatches %0d", mdl_branches, n_errors);
        if (n_errors == 0 && awaited_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
